// File: rtl/core/bat_pkg.sv
// Shared types and codes for the block arrival tracker.
// Holds function, result kind and register codes and the scan unit structs.
// No dependencies.
`default_nettype none

package bat_pkg;

    localparam int DEF_MAX_BLOCKS = 4096;
    localparam int DEF_MAX_REPORT = 64;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;
    localparam int RANGE_W    = 7;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BLOCKS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGES   = 4'd1;

    typedef enum logic [2:0] {
        KIND_WRITE = 3'd0,
        KIND_GAP   = 3'd1,
        KIND_DONE  = 3'd2,
        KIND_ERROR = 3'd3,
        KIND_CLEAR = 3'd4
    } kind_t;

    // Request to the bit search unit: search one bitmap word from a bit offset.
    // Bits at or above valid_bits lie past the image end and read as written.
    typedef struct packed {
        logic [31:0] word;
        logic [4:0]  offset;
        logic [5:0]  valid_bits;
        logic        find_one;
    } scan_req_t;

    typedef struct packed {
        logic       found;
        logic [4:0] pos;
    } scan_res_t;

endpackage

`default_nettype wire

// File: rtl/core/bat_map.sv
// Bitmap storage of the block arrival tracker: one 32-bit word per 32 blocks.
// One write port and one read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module bat_map #(
    parameter int WORDS = 128,
    parameter int AW    = 7
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [31:0]        rdata
);

    logic [31:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/bat_scan.sv
// Shared bit search unit: finds the lowest bit at or above an offset in one
// bitmap word that is set (find_one) or clear. Uses bat_pkg structs.
`default_nettype none

module bat_scan (
    input  wire bat_pkg::scan_req_t req,
    output bat_pkg::scan_res_t      res
);
    import bat_pkg::*;

    logic [31:0] eff;
    logic [31:0] above;
    logic [31:0] cand;
    logic [31:0] lowest;
    logic [4:0]  pos;

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            eff[i]   = (6'(i) >= req.valid_bits) ? 1'b1 : req.word[i];
            above[i] = (5'(i) >= req.offset);
        end
        cand   = (req.find_one ? eff : ~eff) & above;
        lowest = cand & (~cand + 32'd1);
        pos    = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (lowest[i])
            begin
                pos = pos | 5'(i);
            end
        end
        res.found = |cand;
        res.pos   = pos;
    end

endmodule

`default_nettype wire

// File: rtl/core/block_arrival_tracker_core.sv
// Top level of the block arrival tracker: sequencer, config registers and
// output register around the bitmap (bat_map) and bit search unit (bat_scan).
// Depends on bat_pkg.
//
//   channel | direction | handshake             | payload
//   in      | into      | in_valid / in_stall   | func, block_index, data_word
//   out     | out of    | out_valid / out_stall | kind .. last (one item per result)
//   cfg     | into      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A write steps through accept, bitmap read, check and update, and result.
// A query visits each bitmap word in a read and an evaluate step, set by the
// single read port and the shared search unit, and passes through a skip step,
// run end and emit for each reported range.
// After reset and for every clear item taken while image_blocks is at most MAX_BLOCKS
// the bitmap is swept to zero, one word a cycle, and no item is accepted meanwhile.
// A stalled output holds the sequencer in its result state; the next item is
// accepted while the last result of the previous one still waits.
`default_nettype none

module block_arrival_tracker_core #(
    parameter int MAX_BLOCKS = bat_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_REPORT = bat_pkg::DEF_MAX_REPORT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     func,
    input  wire logic [15:0]                    block_index,
    input  wire logic [31:0]                    data_word,

    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [2:0]                          kind,
    output logic                                program_flash,
    output logic [11:0]                         program_index,
    output logic [31:0]                         program_data,
    output logic [11:0]                         gap_start,
    output logic [12:0]                         gap_length,
    output logic [12:0]                         written_count,
    output logic                                last,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bat_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bat_pkg::*;

    localparam int MAP_WORDS = (MAX_BLOCKS + 31) / 32;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int POS_W     = $clog2(MAX_BLOCKS + 1);
    localparam int STEP_W    = POS_W + 2;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_WR_RD,
        ST_WR_CHK,
        ST_RESP,
        ST_SK_RD,
        ST_SK_EVAL,
        ST_SK_STEP,
        ST_RUN_RD,
        ST_RUN_EVAL,
        ST_RUN_END,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       sweep_addr_reg, sweep_addr_next;
    logic                sweep_reply_reg, sweep_reply_next;
    logic [12:0]         image_blocks_reg, image_blocks_next;
    logic [RANGE_W-1:0]  max_ranges_reg, max_ranges_next;
    logic [POS_W-1:0]    count_reg, count_next;
    logic [POS_W-1:0]    cursor_reg, cursor_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    old_reg, old_next;
    logic [POS_W-1:0]    start_reg, start_next;
    logic [POS_W-1:0]    len_reg, len_next;
    logic [POS_W-1:0]    hit_reg, hit_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [RANGE_W-1:0]  cnt_reg, cnt_next;
    logic                wrapped_reg, wrapped_next;
    logic                first_reg, first_next;
    logic                emit_last_reg, emit_last_next;
    logic [POS_W-1:0]    idx_reg, idx_next;
    logic [31:0]         data_reg, data_next;
    kind_t               resp_kind_reg, resp_kind_next;
    logic                resp_pf_reg, resp_pf_next;

    logic                out_valid_reg, out_valid_next;
    kind_t               out_kind_reg, out_kind_next;
    logic                out_pf_reg, out_pf_next;
    logic [11:0]         out_pidx_reg, out_pidx_next;
    logic [31:0]         out_pdata_reg, out_pdata_next;
    logic [11:0]         out_gstart_reg, out_gstart_next;
    logic [12:0]         out_glen_reg, out_glen_next;
    logic [12:0]         out_count_reg, out_count_next;
    logic                out_last_reg, out_last_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [31:0]         mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [31:0]         mem_rdata;

    scan_req_t           scan_req;
    scan_res_t           scan_res;

    logic                img_over;
    logic [POS_W-1:0]    n_eff;
    logic [RANGE_W-1:0]  lim;
    logic                out_free;
    logic                accept;
    logic [POS_W-1:0]    base;
    logic [POS_W-1:0]    diff;
    logic [POS_W:0]      next_base;
    logic                past_end;
    logic [POS_W-1:0]    hit;
    logic [STEP_W-1:0]   skip_len;
    logic [STEP_W-1:0]   step_sum;
    logic [POS_W-1:0]    run_len;
    logic [POS_W-1:0]    run_cursor;
    logic [RANGE_W-1:0]  cnt_inc;
    logic [31:0]         count_wide;
    logic [31:0]         idx_wide;
    logic [31:0]         start_wide;
    logic [31:0]         len_wide;

    bat_map #(
        .WORDS (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bat_scan u_scan (
        .req (scan_req),
        .res (scan_res)
    );

    assign img_over  = 32'(image_blocks_reg) > 32'(MAX_BLOCKS);
    assign n_eff     = img_over ? POS_W'(MAX_BLOCKS) : POS_W'(image_blocks_reg);
    assign lim       = (max_ranges_reg > RANGE_W'(MAX_REPORT)) ? RANGE_W'(MAX_REPORT)
                                                               : max_ranges_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Word-granular view of the scan pointer.
    assign base      = {pos_reg[POS_W-1:5], 5'b0};
    assign diff      = n_eff - base;
    assign next_base = (POS_W+1)'(base) + (POS_W+1)'(32);
    assign past_end  = next_base >= (POS_W+1)'(n_eff);
    assign hit       = base + POS_W'(scan_res.pos);

    assign scan_req.word       = mem_rdata;
    assign scan_req.offset     = pos_reg[4:0];
    assign scan_req.valid_bits = (diff >= POS_W'(32)) ? 6'd32 : diff[5:0];
    assign scan_req.find_one   = (state_reg == ST_RUN_EVAL);

    assign mem_raddr = (state_reg == ST_WR_RD) ? AW'(idx_reg >> 5) : AW'(pos_reg >> 5);

    // Distance moved by a skip; a wrapped skip passes the image end once.
    assign skip_len = wrapped_reg ? (STEP_W'(n_eff) + STEP_W'(hit_reg) - STEP_W'(old_reg))
                                  : (STEP_W'(hit_reg) - STEP_W'(old_reg));
    assign step_sum = step_reg + skip_len;

    assign run_len    = hit_reg - start_reg;
    assign run_cursor = (hit_reg >= n_eff) ? '0 : hit_reg;
    assign cnt_inc    = cnt_reg + RANGE_W'(1);

    assign count_wide = 32'(count_reg);
    assign idx_wide   = 32'(idx_reg);
    assign start_wide = 32'(start_reg);
    assign len_wide   = 32'(len_reg);

    always_comb
    begin
        state_next        = state_reg;
        sweep_addr_next   = sweep_addr_reg;
        sweep_reply_next  = sweep_reply_reg;
        image_blocks_next = image_blocks_reg;
        max_ranges_next   = max_ranges_reg;
        count_next        = count_reg;
        cursor_next       = cursor_reg;
        pos_next          = pos_reg;
        old_next          = old_reg;
        start_next        = start_reg;
        len_next          = len_reg;
        hit_next          = hit_reg;
        step_next         = step_reg;
        cnt_next          = cnt_reg;
        wrapped_next      = wrapped_reg;
        first_next        = first_reg;
        emit_last_next    = emit_last_reg;
        idx_next          = idx_reg;
        data_next         = data_reg;
        resp_kind_next    = resp_kind_reg;
        resp_pf_next      = resp_pf_reg;

        out_valid_next    = out_valid_reg && out_stall;
        out_kind_next     = out_kind_reg;
        out_pf_next       = out_pf_reg;
        out_pidx_next     = out_pidx_reg;
        out_pdata_next    = out_pdata_reg;
        out_gstart_next   = out_gstart_reg;
        out_glen_next     = out_glen_reg;
        out_count_next    = out_count_reg;
        out_last_next     = out_last_reg;

        mem_we    = 1'b0;
        mem_waddr = AW'(idx_reg >> 5);
        mem_wdata = mem_rdata;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_BLOCKS: image_blocks_next = cfg_data[12:0];
                REG_MAX_RANGES:   max_ranges_next   = cfg_data[RANGE_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_addr_reg;
                mem_wdata = '0;
                if (sweep_addr_reg == AW'(MAP_WORDS - 1))
                begin
                    sweep_addr_next = '0;
                    state_next      = sweep_reply_reg ? ST_RESP : ST_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    resp_pf_next   = 1'b0;
                    resp_kind_next = KIND_ERROR;
                    state_next     = ST_RESP;
                    case (func)
                        FUNC_CLEAR:
                        begin
                            if (!img_over)
                            begin
                                count_next       = '0;
                                cursor_next      = '0;
                                sweep_addr_next  = '0;
                                sweep_reply_next = 1'b1;
                                resp_kind_next   = KIND_CLEAR;
                                state_next       = ST_SWEEP;
                            end
                        end
                        FUNC_WRITE:
                        begin
                            idx_next  = POS_W'(block_index);
                            data_next = data_word;
                            if (32'(block_index) < 32'(MAX_BLOCKS))
                            begin
                                state_next = ST_WR_RD;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            if (max_ranges_reg != '0)
                            begin
                                if (n_eff == '0)
                                begin
                                    cursor_next    = '0;
                                    resp_kind_next = KIND_DONE;
                                end
                                else
                                begin
                                    // A cursor left past the image end restarts at zero.
                                    if (cursor_reg >= n_eff)
                                    begin
                                        cursor_next = '0;
                                        pos_next    = '0;
                                        old_next    = '0;
                                    end
                                    else
                                    begin
                                        pos_next = cursor_reg;
                                        old_next = cursor_reg;
                                    end
                                    wrapped_next = 1'b0;
                                    first_next   = 1'b1;
                                    step_next    = '0;
                                    cnt_next     = '0;
                                    state_next   = ST_SK_RD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_WR_RD:
            begin
                state_next = ST_WR_CHK;
            end

            ST_WR_CHK:
            begin
                resp_kind_next = KIND_WRITE;
                state_next     = ST_RESP;
                if (mem_rdata[idx_reg[4:0]])
                begin
                    resp_pf_next = 1'b0;
                end
                else
                begin
                    mem_we       = 1'b1;
                    mem_wdata    = mem_rdata | (32'd1 << idx_reg[4:0]);
                    count_next   = count_reg + POS_W'(1);
                    resp_pf_next = 1'b1;
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = resp_kind_reg;
                    out_pf_next     = resp_pf_reg;
                    out_pidx_next   = resp_pf_reg ? idx_wide[11:0] : 12'd0;
                    out_pdata_next  = resp_pf_reg ? data_reg : 32'd0;
                    out_gstart_next = 12'd0;
                    out_glen_next   = 13'd0;
                    out_count_next  = count_wide[12:0];
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_SK_RD:
            begin
                state_next = ST_SK_EVAL;
            end

            ST_SK_EVAL:
            begin
                if (scan_res.found)
                begin
                    hit_next   = hit;
                    state_next = ST_SK_STEP;
                end
                else if (past_end)
                begin
                    if (!wrapped_reg)
                    begin
                        wrapped_next = 1'b1;
                        pos_next     = '0;
                        state_next   = ST_SK_RD;
                    end
                    else if (first_reg)
                    begin
                        // Every block of the image is written.
                        resp_pf_next   = 1'b0;
                        resp_kind_next = KIND_DONE;
                        state_next     = ST_RESP;
                    end
                    else
                    begin
                        emit_last_next = 1'b1;
                        state_next     = ST_EMIT;
                    end
                end
                else
                begin
                    pos_next   = next_base[POS_W-1:0];
                    state_next = ST_SK_RD;
                end
            end

            ST_SK_STEP:
            begin
                cursor_next = hit_reg;
                if (first_reg)
                begin
                    first_next = 1'b0;
                    start_next = hit_reg;
                    pos_next   = hit_reg;
                    state_next = ST_RUN_RD;
                end
                else
                begin
                    step_next      = step_sum;
                    emit_last_next = (step_sum >= STEP_W'(n_eff));
                    state_next     = ST_EMIT;
                end
            end

            ST_RUN_RD:
            begin
                state_next = ST_RUN_EVAL;
            end

            ST_RUN_EVAL:
            begin
                if (scan_res.found)
                begin
                    hit_next   = hit;
                    state_next = ST_RUN_END;
                end
                else if (past_end)
                begin
                    hit_next   = n_eff;
                    state_next = ST_RUN_END;
                end
                else
                begin
                    pos_next   = next_base[POS_W-1:0];
                    state_next = ST_RUN_RD;
                end
            end

            ST_RUN_END:
            begin
                len_next    = run_len;
                step_next   = step_reg + STEP_W'(run_len);
                cursor_next = run_cursor;
                cnt_next    = cnt_inc;
                if (cnt_inc >= lim)
                begin
                    emit_last_next = 1'b1;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    // Whether this range is the last one is known after the next skip.
                    old_next     = run_cursor;
                    pos_next     = run_cursor;
                    wrapped_next = 1'b0;
                    state_next   = ST_SK_RD;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_GAP;
                    out_pf_next     = 1'b0;
                    out_pidx_next   = 12'd0;
                    out_pdata_next  = 32'd0;
                    out_gstart_next = start_wide[11:0];
                    out_glen_next   = len_wide[12:0];
                    out_count_next  = count_wide[12:0];
                    out_last_next   = emit_last_reg;
                    if (emit_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        start_next = cursor_reg;
                        pos_next   = cursor_reg;
                        state_next = ST_RUN_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_SWEEP;
            sweep_addr_reg   <= '0;
            sweep_reply_reg  <= 1'b0;
            image_blocks_reg <= 13'd0;
            max_ranges_reg   <= RANGE_W'(16);
            count_reg        <= '0;
            cursor_reg       <= '0;
            pos_reg          <= '0;
            old_reg          <= '0;
            start_reg        <= '0;
            len_reg          <= '0;
            hit_reg          <= '0;
            step_reg         <= '0;
            cnt_reg          <= '0;
            wrapped_reg      <= 1'b0;
            first_reg        <= 1'b0;
            emit_last_reg    <= 1'b0;
            resp_kind_reg    <= KIND_ERROR;
            resp_pf_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_kind_reg     <= KIND_ERROR;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_reply_reg  <= sweep_reply_next;
            image_blocks_reg <= image_blocks_next;
            max_ranges_reg   <= max_ranges_next;
            count_reg        <= count_next;
            cursor_reg       <= cursor_next;
            pos_reg          <= pos_next;
            old_reg          <= old_next;
            start_reg        <= start_next;
            len_reg          <= len_next;
            hit_reg          <= hit_next;
            step_reg         <= step_next;
            cnt_reg          <= cnt_next;
            wrapped_reg      <= wrapped_next;
            first_reg        <= first_next;
            emit_last_reg    <= emit_last_next;
            resp_kind_reg    <= resp_kind_next;
            resp_pf_reg      <= resp_pf_next;
            out_valid_reg    <= out_valid_next;
            out_kind_reg     <= out_kind_next;
            out_last_reg     <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        data_reg       <= data_next;
        out_pf_reg     <= out_pf_next;
        out_pidx_reg   <= out_pidx_next;
        out_pdata_reg  <= out_pdata_next;
        out_gstart_reg <= out_gstart_next;
        out_glen_reg   <= out_glen_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign program_flash = out_pf_reg;
    assign program_index = out_pidx_reg;
    assign program_data  = out_pdata_reg;
    assign gap_start     = out_gstart_reg;
    assign gap_length    = out_glen_reg;
    assign written_count = out_count_reg;
    assign last          = out_last_reg;

endmodule

`default_nettype wire
